### rtl/assert_macros.svh
// Assertion macros used by the checker file mett_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

### rtl/mett_pkg.sv
// Shared types and constants for the expression tokenizer.
`default_nettype none

package mett_pkg;

    // Width of the number value on the output port
    localparam int VALUE_W = 32;

    // Token queue between the front and back parts
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef enum logic [4:0] {
        TK_NUMBER = 5'd0,
        TK_X      = 5'd1,
        TK_EXP    = 5'd2,
        TK_LN     = 5'd3,
        TK_SIN    = 5'd4,
        TK_COS    = 5'd5,
        TK_TG     = 5'd6,
        TK_CTG    = 5'd7,
        TK_PLUS   = 5'd8,
        TK_MINUS  = 5'd9,
        TK_TIMES  = 5'd10,
        TK_DIVIDE = 5'd11,
        TK_LPAREN = 5'd12,
        TK_RPAREN = 5'd13,
        TK_POWER  = 5'd14,
        TK_EOL    = 5'd15,
        TK_ERROR  = 5'd16
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_NAME   = 2'd1,
        ERR_SYMBOL = 2'd2
    } err_code_t;

    // One queue entry: the tokens caused by one character
    typedef struct packed {
        logic                has_num;
        logic [VALUE_W-1:0]  num_value;
        logic                num_sat;
        logic                has_tok;
        tok_kind_t           tok_kind;
        err_code_t           tok_err;
    } frame_t;

endpackage

`default_nettype wire

### rtl/mett_front.sv
// Front part: accepts characters, tracks prefix and digit runs, builds token frames.
`default_nettype none

module mett_front
    import mett_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  char_code,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        q_full,
    output logic             q_push,
    output frame_t           q_frame
);

    localparam int NUM_BITS = (NUMBER_WIDTH > VALUE_W) ? VALUE_W : NUMBER_WIDTH;
    localparam int PROD_W   = NUM_BITS + 4;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;

    // Partial function name seen so far
    typedef enum logic [3:0] {
        PX_NONE, PX_E, PX_EX, PX_L, PX_S, PX_SI, PX_C, PX_CO, PX_T, PX_CT
    } prefix_t;

    prefix_t              prefix_reg, prefix_next;
    logic                 in_num_reg, in_num_next;
    logic [NUM_BITS-1:0]  acc_reg, acc_next;
    logic                 sat_reg, sat_next;
    logic                 hold_reg, hold_next;

    logic                 fire;
    logic [PROD_W-1:0]    prod;
    logic                 overflow;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    // acc * 10 + digit, with room to detect overflow
    assign prod = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1)
                + PROD_W'(char_code[3:0]);
    assign overflow = sat_reg || (prod[PROD_W-1:NUM_BITS] != 4'd0);

    // Character decode and next state
    always_comb
    begin
        logic      fail;
        err_code_t fail_err;

        fail        = 1'b0;
        fail_err    = ERR_NONE;
        prefix_next = prefix_reg;
        in_num_next = in_num_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        hold_next   = hold_reg;
        q_frame     = '0;

        if (fire)
        begin
            if (hold_reg)
            begin
                // skip everything up to a newline
                if (char_code == CH_LF)
                begin
                    hold_next        = 1'b0;
                    prefix_next      = PX_NONE;
                    q_frame.has_tok  = 1'b1;
                    q_frame.tok_kind = TK_EOL;
                end
            end
            else if (char_code >= CH_ZERO && char_code <= CH_NINE)
            begin
                if (prefix_reg != PX_NONE)
                begin
                    fail     = 1'b1;
                    fail_err = ERR_NAME;
                end
                else
                begin
                    in_num_next = 1'b1;
                    if (overflow)
                    begin
                        acc_next = '1;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = prod[NUM_BITS-1:0];
                    end
                end
            end
            else
            begin
                // a non-digit closes any open digit run
                if (in_num_reg)
                begin
                    q_frame.has_num   = 1'b1;
                    q_frame.num_value = VALUE_W'(acc_reg);
                    q_frame.num_sat   = sat_reg;
                    in_num_next       = 1'b0;
                    acc_next          = '0;
                    sat_next          = 1'b0;
                end

                unique case (char_code)
                    CH_LF:
                    begin
                        q_frame.has_tok  = 1'b1;
                        q_frame.tok_kind = TK_EOL;
                        prefix_next      = PX_NONE;
                    end
                    CH_SPACE: ;
                    CH_E:
                    begin
                        if (prefix_reg == PX_NONE) prefix_next = PX_E;
                        else fail = 1'b1;
                    end
                    CH_X:
                    begin
                        if (prefix_reg == PX_E) prefix_next = PX_EX;
                        else if (prefix_reg == PX_NONE)
                        begin
                            q_frame.has_tok  = 1'b1;
                            q_frame.tok_kind = TK_X;
                        end
                        else fail = 1'b1;
                    end
                    CH_P:
                    begin
                        if (prefix_reg == PX_EX)
                        begin
                            q_frame.has_tok  = 1'b1;
                            q_frame.tok_kind = TK_EXP;
                            prefix_next      = PX_NONE;
                        end
                        else fail = 1'b1;
                    end
                    CH_L:
                    begin
                        if (prefix_reg == PX_NONE) prefix_next = PX_L;
                        else fail = 1'b1;
                    end
                    CH_N:
                    begin
                        if (prefix_reg == PX_L || prefix_reg == PX_SI)
                        begin
                            q_frame.has_tok  = 1'b1;
                            q_frame.tok_kind = (prefix_reg == PX_L) ? TK_LN : TK_SIN;
                            prefix_next      = PX_NONE;
                        end
                        else fail = 1'b1;
                    end
                    CH_C:
                    begin
                        if (prefix_reg == PX_NONE) prefix_next = PX_C;
                        else fail = 1'b1;
                    end
                    CH_O:
                    begin
                        if (prefix_reg == PX_C) prefix_next = PX_CO;
                        else fail = 1'b1;
                    end
                    CH_S:
                    begin
                        if (prefix_reg == PX_CO)
                        begin
                            q_frame.has_tok  = 1'b1;
                            q_frame.tok_kind = TK_COS;
                            prefix_next      = PX_NONE;
                        end
                        else if (prefix_reg == PX_NONE) prefix_next = PX_S;
                        else fail = 1'b1;
                    end
                    CH_I:
                    begin
                        if (prefix_reg == PX_S) prefix_next = PX_SI;
                        else fail = 1'b1;
                    end
                    CH_T:
                    begin
                        if (prefix_reg == PX_C) prefix_next = PX_CT;
                        else if (prefix_reg == PX_NONE) prefix_next = PX_T;
                        else fail = 1'b1;
                    end
                    CH_G:
                    begin
                        if (prefix_reg == PX_T || prefix_reg == PX_CT)
                        begin
                            q_frame.has_tok  = 1'b1;
                            q_frame.tok_kind = (prefix_reg == PX_T) ? TK_TG : TK_CTG;
                            prefix_next      = PX_NONE;
                        end
                        else fail = 1'b1;
                    end
                    // operators leave a pending prefix in place
                    CH_PLUS:
                    begin
                        q_frame.has_tok  = 1'b1;
                        q_frame.tok_kind = TK_PLUS;
                    end
                    CH_MINUS:
                    begin
                        q_frame.has_tok  = 1'b1;
                        q_frame.tok_kind = TK_MINUS;
                    end
                    CH_STAR:
                    begin
                        q_frame.has_tok  = 1'b1;
                        q_frame.tok_kind = TK_TIMES;
                    end
                    CH_SLASH:
                    begin
                        q_frame.has_tok  = 1'b1;
                        q_frame.tok_kind = TK_DIVIDE;
                    end
                    CH_LPAREN:
                    begin
                        q_frame.has_tok  = 1'b1;
                        q_frame.tok_kind = TK_LPAREN;
                    end
                    CH_RPAREN:
                    begin
                        q_frame.has_tok  = 1'b1;
                        q_frame.tok_kind = TK_RPAREN;
                    end
                    CH_CARET:
                    begin
                        q_frame.has_tok  = 1'b1;
                        q_frame.tok_kind = TK_POWER;
                    end
                    default:
                    begin
                        fail     = 1'b1;
                        fail_err = ERR_SYMBOL;
                    end
                endcase

                if (fail && fail_err == ERR_NONE)
                    fail_err = ERR_NAME;
            end

            // error token; input is dropped until newline
            if (fail)
            begin
                q_frame.has_tok  = 1'b1;
                q_frame.tok_kind = TK_ERROR;
                q_frame.tok_err  = fail_err;
                prefix_next      = PX_NONE;
                hold_next        = 1'b1;
            end
        end

        q_push = q_frame.has_num || q_frame.has_tok;
    end

    // Tokenizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= PX_NONE;
            in_num_reg <= 1'b0;
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
            hold_reg   <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            in_num_reg <= in_num_next;
            acc_reg    <= acc_next;
            sat_reg    <= sat_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mett_queue.sv
// Short frame queue between the front and back parts.
`default_nettype none

module mett_queue
    import mett_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire frame_t  push_frame,
    input  wire logic    pop,
    output frame_t       head,
    output logic         empty,
    output logic         full
);

    frame_t              mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head  = mem[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_frame;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/mett_back.sv
// Back part: splits frames into tokens and drives the output register.
`default_nettype none

module mett_back
    import mett_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire frame_t              head,
    input  wire logic                q_empty,
    output logic                     q_pop,
    output logic [4:0]               token_kind,
    output logic [VALUE_W-1:0]       number_value,
    output logic                     number_saturated,
    output logic [1:0]               error_code,
    output logic                     last_of_run,
    output logic                     out_valid,
    input  wire logic                out_ready
);

    logic                 valid_reg, valid_next;
    logic                 phase_reg, phase_next;
    tok_kind_t            kind_reg, kind_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic                 sat_reg, sat_next;
    err_code_t            err_reg, err_next;
    logic                 last_reg, last_next;
    logic                 load;

    assign load = !valid_reg || out_ready;

    // Pick the next token: number part first, then the character's own token
    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        sat_next   = sat_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;

        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                if (head.has_num && !phase_reg)
                begin
                    kind_next  = TK_NUMBER;
                    value_next = head.num_value;
                    sat_next   = head.num_sat;
                    err_next   = ERR_NONE;
                    last_next  = !head.has_tok;
                    phase_next = head.has_tok;
                    q_pop      = !head.has_tok;
                end
                else
                begin
                    kind_next  = head.tok_kind;
                    value_next = '0;
                    sat_next   = 1'b0;
                    err_next   = head.tok_err;
                    last_next  = 1'b1;
                    phase_next = 1'b0;
                    q_pop      = 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        sat_reg   <= sat_next;
        err_reg   <= err_next;
        last_reg  <= last_next;
    end

    assign out_valid        = valid_reg;
    assign token_kind       = kind_reg;
    assign number_value     = value_reg;
    assign number_saturated = sat_reg;
    assign error_code       = err_reg;
    assign last_of_run      = last_reg;

endmodule

`default_nettype wire

### rtl/math_expression_tokenizer_unit.sv
// Top level of the expression tokenizer: front, frame queue and back.
// A character's tokens pass through the frame queue and then the output register.
// Throughput: one character per cycle while the queue is not full; a character
// that closes a digit run and has its own token gives two output tokens, absorbed by a 4-entry queue.
// Reset (rst_n low, asynchronous) clears prefix, digit run, error hold, queue
// and output valid; the block accepts characters as soon as reset is released.
`default_nettype none

module math_expression_tokenizer_unit
    import mett_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          char_code,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic [4:0]               token_kind,
    output logic [VALUE_W-1:0]       number_value,
    output logic                     number_saturated,
    output logic [1:0]               error_code,
    output logic                     last_of_run,
    output logic                     out_valid,
    input  wire logic                out_ready
);

    frame_t push_frame;
    frame_t head;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;

    mett_front #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_full    (q_full),
        .q_push    (push),
        .q_frame   (push_frame)
    );

    mett_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    mett_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .q_empty          (q_empty),
        .q_pop            (pop),
        .token_kind       (token_kind),
        .number_value     (number_value),
        .number_saturated (number_saturated),
        .error_code       (error_code),
        .last_of_run      (last_of_run),
        .out_valid        (out_valid),
        .out_ready        (out_ready)
    );

endmodule

`default_nettype wire

### rtl/mett_checker.sv
// Port-level checks for the expression tokenizer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mett_checker
    import mett_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          char_code,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [4:0]          token_kind,
    input  wire logic [VALUE_W-1:0]  number_value,
    input  wire logic                number_saturated,
    input  wire logic [1:0]          error_code,
    input  wire logic                last_of_run,
    input  wire logic                out_valid,
    input  wire logic                out_ready
);

    logic is_num;
    logic is_err;
    logic in_seen;

    assign is_num  = (token_kind == TK_NUMBER);
    assign is_err  = (token_kind == TK_ERROR);
    assign in_seen = in_valid && in_ready && (char_code != 8'h00);

    // Stalled transaction holds valid and payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(number_value) && $stable(error_code) && $stable(last_of_run))

    // Only number tokens carry a value or saturation flag
    `ASSERT_IMPLIES(a_num_fields, clk, rst_n, out_valid && !is_num, number_value == '0 && !number_saturated)

    // Error code present exactly on error tokens
    `ASSERT_IMPLIES(a_err_code, clk, rst_n, out_valid, is_err == (error_code != ERR_NONE))

    // Anything but a number token ends its character's run
    `ASSERT_IMPLIES(a_last_run, clk, rst_n, out_valid && !is_num, last_of_run || in_seen)

endmodule

bind math_expression_tokenizer_unit mett_checker u_mett_checker (.*);

`default_nettype wire
